// ----- design/wfq_pkg.sv -----
// Shared types, widths, register indexes and helpers of the fair queue scheduler.
package wfq_pkg;

   localparam int TAG_W      = 16;
   localparam int SIZE_W     = 14;
   localparam int TIME_W     = 48;
   localparam int PRIO_REQ_W = 2;
   localparam int BYTES_W    = 24;
   localparam int WEIGHT_W   = 8;
   localparam int BT_W       = 16;
   localparam int NUM_WREG   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int LFSR_W     = 16;

   // sum of weights over at most eight classes fits 11 bits
   localparam int SUM_W      = 11;
   localparam int PROD1_W    = SIZE_W + BT_W;
   localparam int PROD_W     = PROD1_W + SUM_W;
   localparam int DIV_DIGIT  = 4;
   localparam int DIV_W      = ((PROD_W + DIV_DIGIT - 1) / DIV_DIGIT) * DIV_DIGIT;
   localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
   localparam int DIV_DEN_W  = WEIGHT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_TIME  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BUF_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TIE_WINDOW = 3'd6;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 8'd1;
   localparam logic [BT_W-1:0]     BYTE_TIME_RST = 16'd800;
   localparam logic [BYTES_W-1:0]  BUF_LIMIT_RST = 24'd65536;
   localparam logic [TIME_W-1:0]   TIE_RST       = 48'd10000000000;
   localparam logic [LFSR_W-1:0]   LFSR_SEED     = 16'hACE1;

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENQ_CHK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SCAN,
      ST_MIN,
      ST_TIE,
      ST_MOD_GO,
      ST_MOD,
      ST_RD,
      ST_DEQ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] enq_time;
      logic [TIME_W-1:0] finish;
   } row_type;

   typedef struct packed {
      logic                  accepted;
      logic                  dropped;
      logic [TAG_W-1:0]      out_tag;
      logic [PRIO_REQ_W-1:0] out_priority;
      logic [SIZE_W-1:0]     out_size;
      logic [TIME_W-1:0]     queue_delay;
      logic [BYTES_W-1:0]    queued_bytes;
   } rsp_type;

   // Fibonacci LFSR, taps 16,14,13,11
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
      logic b;
      b = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {b, l[LFSR_W-1:1]};
   endfunction

endpackage

// ----- design/wfq_if.sv -----
// Request and response channel interfaces of the fair queue scheduler.
interface wfq_req_if;
   import wfq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [TIME_W-1:0]     now;
   logic [PRIO_REQ_W-1:0] priority_req;
   logic [SIZE_W-1:0]     pkt_size;
   logic [TAG_W-1:0]      pkt_tag;
   modport source (output valid, req_type, now, priority_req, pkt_size, pkt_tag,
                   input ready);
   modport sink   (input valid, req_type, now, priority_req, pkt_size, pkt_tag,
                   output ready);
endinterface

interface wfq_rsp_if;
   import wfq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  accepted;
   logic                  dropped;
   logic [TAG_W-1:0]      out_tag;
   logic [PRIO_REQ_W-1:0] out_priority;
   logic [SIZE_W-1:0]     out_size;
   logic [TIME_W-1:0]     queue_delay;
   logic [BYTES_W-1:0]    queued_bytes;
   modport source (output valid, accepted, dropped, out_tag, out_priority, out_size,
                   queue_delay, queued_bytes, input ready);
   modport sink   (input valid, accepted, dropped, out_tag, out_priority, out_size,
                   queue_delay, queued_bytes, output ready);
endinterface

// ----- design/wfq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/wfq_div.sv -----
// Radix-16 restoring divider: quotient and remainder, four bits per cycle.
module wfq_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wfq_pkg::DIV_W-1:0]         num,
   input  logic [wfq_pkg::DIV_DEN_W-1:0]     den,
   output logic                              done,
   output logic [wfq_pkg::DIV_W-1:0]         quo,
   output logic [wfq_pkg::DIV_DEN_W-1:0]     rem
);
   import wfq_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [DIV_W-1:0]     q_ff;
   logic [DIV_DEN_W-1:0] r_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_W-1:0]     q_in;
   logic [DIV_DEN_W-1:0] r_in;

   always_comb begin
      logic [DIV_DEN_W:0]   t;
      logic [DIV_DEN_W-1:0] r;
      logic [DIV_W-1:0]     q;
      r = r_ff;
      q = q_ff;
      for (int k = 0; k < DIV_DIGIT; k++) begin
         t = {r, q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t    = t - {1'b0, den_ff};
            q[0] = 1'b1;
         end
         r = t[DIV_DEN_W-1:0];
      end
      q_in = q;
      r_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIV_STEPS);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         r_ff   <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule

// ----- design/weighted_fair_queue_scheduler_core.sv -----
// Weighted fair queuing scheduler over NUM_PRIO FIFOs held in one packet RAM.
// One request is in work at a time. An enqueue presents its response after two
// registered multiplies and an 11-step radix-16 divide of the scaled size by the
// class weight; a dropped enqueue skips the multiplies and the divide. A dequeue
// scans the class heads through the single RAM read port and compares one head
// per cycle; when all weights are equal a tie pass follows and, with two or more
// tied heads, the divider then serves the LFSR modulo. A dequeue with every class
// empty responds without a scan. The next request is taken in the cycle after the
// response is loaded; the response waits in the output register meanwhile, and a
// stalled response holds the sequencer.
// The packet RAM needs no clearing after reset.
module weighted_fair_queue_scheduler_core #(
   parameter int NUM_PRIO   = 4,
   parameter int FIFO_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   wfq_req_if.sink                        req_ch,
   wfq_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [wfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wfq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wfq_pkg::*;

   localparam int PRIO_W = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
   localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int NCND_W = $clog2(NUM_PRIO + 1);
   localparam int RAM_DEPTH = NUM_PRIO << PTR_W;
   localparam int ADDR_W = $clog2(RAM_DEPTH);
   localparam int ROW_W  = $bits(row_type);

   state_type state_ff, state_in;

   // configuration
   logic [WEIGHT_W-1:0] weight_ff [NUM_WREG];
   logic [BT_W-1:0]     byte_time_ff;
   logic [BYTES_W-1:0]  limit_ff;
   logic [TIME_W-1:0]   tie_ff;

   // per-class control
   logic [PTR_W-1:0]  head_ff [NUM_PRIO];
   logic [PTR_W-1:0]  tail_ff [NUM_PRIO];
   logic [CNT_W-1:0]  cnt_ff  [NUM_PRIO];
   logic [TIME_W-1:0] last_ff [NUM_PRIO];
   logic [NUM_PRIO-1:0] seen_ff;
   logic [TIME_W-1:0] hfin_ff [NUM_PRIO];
   logic [PRIO_W-1:0] cand_ff [NUM_PRIO];
   logic [BYTES_W-1:0] bytes_ff;
   logic [LFSR_W-1:0]  lfsr_ff;

   // request in work
   logic [TIME_W-1:0]     now_ff;
   logic [PRIO_REQ_W-1:0] prio_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [PROD1_W-1:0]    prod1_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [TIME_W-1:0]     start_ff;
   logic [PRIO_W-1:0]     idx_ff;
   logic [PRIO_W-1:0]     rd_idx_ff;
   logic                  rd_pend_ff;
   logic [PRIO_W-1:0]     sel_ff;
   logic [TIME_W-1:0]     min_ff;
   logic                  found_ff;
   logic [NCND_W-1:0]     ncand_ff;
   rsp_type               res_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic                  rsp_valid_ff;

   // comb
   logic [WEIGHT_W-1:0] wt [NUM_PRIO];
   logic [SUM_W-1:0]    wsum;
   logic                eq_w;
   logic                any_ne;
   logic [PRIO_W-1:0]   q;
   logic                drop;
   logic                req_beat;
   logic                rsp_free;
   logic                idx_last;
   logic [TIME_W-1:0]   cur_fin;
   logic                cur_ne;
   logic                is_cand;
   logic [NCND_W-1:0]   ncand_in;
   logic [TIME_W:0]     fin_sum;
   logic [TIME_W-1:0]   fin;
   row_type             rd_row;
   row_type             wr_row;
   logic [ROW_W-1:0]    ram_rdata;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADDR_W-1:0]   ram_raddr;
   logic                div_start;
   logic [DIV_W-1:0]    div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                div_done;
   logic [DIV_W-1:0]    div_quo;
   logic [DIV_DEN_W-1:0] div_rem;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   for (genvar i = 0; i < NUM_PRIO; i++) begin : g_wt
      if (i < NUM_WREG) begin : g_reg
         assign wt[i] = (weight_ff[i] == '0) ? WEIGHT_W'(1) : weight_ff[i];
      end else begin : g_one
         assign wt[i] = WEIGHT_W'(1);
      end
   end

   always_comb begin
      wsum   = '0;
      eq_w   = 1'b1;
      any_ne = 1'b0;
      for (int i = 0; i < NUM_PRIO; i++) begin
         wsum = wsum + SUM_W'(wt[i]);
         if (wt[i] != wt[0]) begin
            eq_w = 1'b0;
         end
         if (cnt_ff[i] != '0) begin
            any_ne = 1'b1;
         end
      end
   end

   assign q        = PRIO_W'(prio_ff);
   assign drop     = (32'(prio_ff) >= NUM_PRIO)
                  || (({1'b0, bytes_ff} + (BYTES_W+1)'(size_ff)) > {1'b0, limit_ff})
                  || (cnt_ff[q] >= CNT_W'(FIFO_DEPTH));
   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign idx_last = (idx_ff == PRIO_W'(NUM_PRIO - 1));
   assign cur_fin  = hfin_ff[idx_ff];
   assign cur_ne   = (cnt_ff[idx_ff] != '0);
   assign is_cand  = cur_ne && ((cur_fin - min_ff) < tie_ff);
   assign ncand_in = ncand_ff + NCND_W'(is_cand);
   assign fin_sum  = (TIME_W+1)'(start_ff) + (TIME_W+1)'(div_quo);
   assign fin      = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
   assign rd_row   = row_type'(ram_rdata);

   always_comb begin
      rsp_in              = res_ff;
      rsp_in.queued_bytes = bytes_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_ch.req_type == REQ_ENQ) begin
                  state_in = ST_ENQ_CHK;
               end else if (any_ne) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ENQ_CHK:  state_in = drop ? ST_DONE : ST_MUL;
         ST_MUL:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: state_in = div_done ? ST_DONE : ST_DIV_WAIT;
         ST_SCAN:     state_in = idx_last ? ST_MIN : ST_SCAN;
         ST_MIN: begin
            if (idx_last) begin
               state_in = eq_w ? ST_TIE : ST_RD;
            end
         end
         ST_TIE: begin
            if (idx_last) begin
               state_in = (ncand_in > NCND_W'(1)) ? ST_MOD_GO : ST_RD;
            end
         end
         ST_MOD_GO:   state_in = ST_MOD;
         ST_MOD:      state_in = div_done ? ST_RD : ST_MOD;
         ST_RD:       state_in = ST_DEQ;
         ST_DEQ:      state_in = ST_DONE;
         ST_DONE:     state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ram_we    = 1'b0;
      ram_raddr = {idx_ff, head_ff[idx_ff]};
      div_start = 1'b0;
      div_num   = DIV_W'(prod_ff);
      div_den   = wt[q];
      case (state_ff)
         ST_DIV_WAIT: ram_we = div_done;
         ST_RD:       ram_raddr = {sel_ff, head_ff[sel_ff]};
         ST_DIV_GO:   div_start = 1'b1;
         ST_MOD_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'(lfsr_ff);
            div_den   = DIV_DEN_W'(ncand_ff);
         end
         default: ram_we = 1'b0;
      endcase
   end

   assign ram_waddr       = {q, tail_ff[q]};
   assign wr_row.tag      = tag_ff;
   assign wr_row.size     = size_ff;
   assign wr_row.enq_time = now_ff;
   assign wr_row.finish   = fin;

   wfq_ram #(
      .WIDTH (ROW_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_row),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wfq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < NUM_WREG; i++) begin
            weight_ff[i] <= WEIGHT_RST;
         end
         byte_time_ff <= BYTE_TIME_RST;
         limit_ff     <= BUF_LIMIT_RST;
         tie_ff       <= TIE_RST;
         for (int i = 0; i < NUM_PRIO; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
         seen_ff      <= '0;
         bytes_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SCAN);
         if (csr_we) begin
            case (csr_index)
               CSR_WEIGHT_0:   weight_ff[0] <= csr_wdata[WEIGHT_W-1:0];
               CSR_WEIGHT_1:   weight_ff[1] <= csr_wdata[WEIGHT_W-1:0];
               CSR_WEIGHT_2:   weight_ff[2] <= csr_wdata[WEIGHT_W-1:0];
               CSR_WEIGHT_3:   weight_ff[3] <= csr_wdata[WEIGHT_W-1:0];
               CSR_BYTE_TIME:  byte_time_ff <= csr_wdata[BT_W-1:0];
               CSR_BUF_LIMIT:  limit_ff     <= csr_wdata[BYTES_W-1:0];
               CSR_TIE_WINDOW: tie_ff       <= csr_wdata[TIME_W-1:0];
               default:        tie_ff       <= tie_ff;
            endcase
         end
         if (state_ff == ST_DIV_WAIT && div_done) begin
            tail_ff[q]  <= ptr_inc(tail_ff[q]);
            cnt_ff[q]   <= cnt_ff[q] + 1'b1;
            last_ff[q]  <= fin;
            seen_ff[q]  <= 1'b1;
            bytes_ff    <= bytes_ff + BYTES_W'(size_ff);
         end
         if (state_ff == ST_MOD && div_done) begin
            lfsr_ff <= lfsr_next(lfsr_ff);
         end
         if (state_ff == ST_DEQ) begin
            head_ff[sel_ff] <= ptr_inc(head_ff[sel_ff]);
            cnt_ff[sel_ff]  <= cnt_ff[sel_ff] - 1'b1;
            bytes_ff        <= bytes_ff - BYTES_W'(rd_row.size);
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         hfin_ff[rd_idx_ff] <= rd_row.finish;
      end
      rd_idx_ff <= idx_ff;
      case (state_ff)
         ST_IDLE: begin
            now_ff   <= req_ch.now;
            prio_ff  <= req_ch.priority_req;
            size_ff  <= req_ch.pkt_size;
            tag_ff   <= req_ch.pkt_tag;
            idx_ff   <= '0;
            found_ff <= 1'b0;
            ncand_ff <= '0;
            res_ff   <= '0;
         end
         ST_ENQ_CHK: begin
            prod1_ff       <= PROD1_W'(size_ff) * PROD1_W'(byte_time_ff);
            res_ff.dropped <= drop;
         end
         ST_MUL: begin
            prod_ff  <= PROD_W'(prod1_ff) * PROD_W'(wsum);
            start_ff <= (seen_ff[q] && last_ff[q] > now_ff) ? last_ff[q] : now_ff;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_ff.accepted <= 1'b1;
            end
         end
         ST_SCAN: begin
            idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
         end
         ST_MIN: begin
            if (cur_ne && (!found_ff || cur_fin < min_ff)) begin
               sel_ff   <= idx_ff;
               min_ff   <= cur_fin;
               found_ff <= 1'b1;
            end
            idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
         end
         ST_TIE: begin
            if (is_cand) begin
               cand_ff[ncand_ff[PRIO_W-1:0]] <= idx_ff;
            end
            ncand_ff <= ncand_in;
            idx_ff   <= idx_last ? '0 : idx_ff + 1'b1;
         end
         ST_MOD: begin
            if (div_done) begin
               sel_ff <= cand_ff[div_rem[PRIO_W-1:0]];
            end
         end
         ST_DEQ: begin
            res_ff <= '{accepted:     1'b1,
                        dropped:      1'b0,
                        out_tag:      rd_row.tag,
                        out_priority: PRIO_REQ_W'(sel_ff),
                        out_size:     rd_row.size,
                        queue_delay:  (now_ff >= rd_row.enq_time) ?
                                      now_ff - rd_row.enq_time : '0,
                        queued_bytes: '0};
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_ff <= rsp_in;
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = rsp_ff.accepted;
   assign rsp_ch.dropped      = rsp_ff.dropped;
   assign rsp_ch.out_tag      = rsp_ff.out_tag;
   assign rsp_ch.out_priority = rsp_ff.out_priority;
   assign rsp_ch.out_size     = rsp_ff.out_size;
   assign rsp_ch.queue_delay  = rsp_ff.queue_delay;
   assign rsp_ch.queued_bytes = rsp_ff.queued_bytes;
endmodule

// ----- tb/weighted_fair_queue_scheduler_core_tb.sv -----
// Self-checking testbench of the weighted fair queue scheduler core.
`timescale 1ns / 100ps

module weighted_fair_queue_scheduler_core_tb;
   import wfq_pkg::*;

   localparam int NUM_PRIO   = 4;
   localparam int FIFO_DEPTH = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct {
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] enq_time;
      logic [TIME_W-1:0] finish;
   } pkt_entry_type;

   typedef struct {
      logic                  kind;
      logic [TIME_W-1:0]     stamp;
      logic [PRIO_REQ_W-1:0] prio;
      logic [SIZE_W-1:0]     size;
      logic [TAG_W-1:0]      tag;
   } sched_req_type;

   class wfq_scoreboard_type;
      pkt_entry_type     fifo_q[NUM_PRIO][$];
      logic [TIME_W-1:0] last_fin[NUM_PRIO];
      bit                fin_seen[NUM_PRIO];
      logic [BYTES_W-1:0] held;
      logic [LFSR_W-1:0] lfsr;
      logic [WEIGHT_W-1:0] weight[NUM_WREG];
      logic [BT_W-1:0]    byte_ps;
      logic [BYTES_W-1:0] buf_limit;
      logic [TIME_W-1:0]  tie_win;
      rsp_type            pending[$];
      int errors, n_stored, n_drops, n_served, n_empty, n_ties, n_checked;

      function new();
         for (int i = 0; i < NUM_PRIO; i++) begin
            last_fin[i] = '0;
            fin_seen[i] = 0;
         end
         for (int i = 0; i < NUM_WREG; i++) weight[i] = WEIGHT_RST;
         held = '0;
         lfsr = LFSR_SEED;
         byte_ps = BYTE_TIME_RST;
         buf_limit = BUF_LIMIT_RST;
         tie_win = TIE_RST;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_WEIGHT_0, CSR_WEIGHT_1, CSR_WEIGHT_2, CSR_WEIGHT_3: begin
               weight[idx] = val[WEIGHT_W-1:0];
            end
            CSR_BYTE_TIME: byte_ps = val[BT_W-1:0];
            CSR_BUF_LIMIT: buf_limit = val[BYTES_W-1:0];
            CSR_TIE_WINDOW: tie_win = val[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned eff_weight(int p);
         longint unsigned w;
         w = (p < NUM_WREG) ? weight[p] : 1;
         return (w == 0) ? 1 : w;
      endfunction

      function void note_request(sched_req_type r);
         rsp_type e;
         longint unsigned sum, start, inc, f, minf;
         int sel, n;
         int cand[NUM_PRIO];
         bit equal;
         pkt_entry_type pe;
         e = '0;
         if (r.kind == REQ_ENQ) begin
            if (r.prio < NUM_PRIO && {1'b0, held} + r.size <= {1'b0, buf_limit}
                && fifo_q[r.prio].size() < FIFO_DEPTH) begin
               sum = 0;
               for (int i = 0; i < NUM_PRIO; i++) sum += eff_weight(i);
               start = r.stamp;
               if (fin_seen[r.prio] && last_fin[r.prio] > start) start = last_fin[r.prio];
               inc = (longint'(r.size) * byte_ps * sum) / eff_weight(r.prio);
               f = (inc > TIME_MAX - start) ? TIME_MAX : start + inc;
               pe.tag = r.tag;
               pe.size = r.size;
               pe.enq_time = r.stamp;
               pe.finish = TIME_W'(f);
               fifo_q[r.prio] = {fifo_q[r.prio], pe};
               held += BYTES_W'(r.size);
               last_fin[r.prio] = TIME_W'(f);
               fin_seen[r.prio] = 1;
               e.accepted = 1;
               n_stored++;
            end else begin
               e.dropped = 1;
               n_drops++;
            end
         end else begin
            sel = -1;
            minf = 0;
            for (int i = 0; i < NUM_PRIO; i++)
               if (fifo_q[i].size() != 0 && (sel < 0 || fifo_q[i][0].finish < minf)) begin
                  sel = i;
                  minf = fifo_q[i][0].finish;
               end
            if (sel < 0) begin
               n_empty++;
            end else begin
               equal = 1;
               for (int i = 1; i < NUM_PRIO; i++)
                  if (eff_weight(i) != eff_weight(0)) equal = 0;
               if (equal) begin
                  n = 0;
                  for (int i = 0; i < NUM_PRIO; i++)
                     if (fifo_q[i].size() != 0 && fifo_q[i][0].finish - minf < tie_win) begin
                        cand[n] = i;
                        n++;
                     end
                  if (n > 1) begin
                     sel = cand[lfsr % n];
                     lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
                     n_ties++;
                  end
               end
               pe = fifo_q[sel][0];
               fifo_q[sel].delete(0);
               held -= BYTES_W'(pe.size);
               e.accepted = 1;
               e.out_tag = pe.tag;
               e.out_priority = sel[PRIO_REQ_W-1:0];
               e.out_size = pe.size;
               e.queue_delay = (r.stamp >= pe.enq_time) ? r.stamp - pe.enq_time : '0;
               n_served++;
            end
         end
         e.queued_bytes = held;
         pending = {pending, e};
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected beat", 64'(got.queued_bytes), 64'd0);
            return;
         end
         e = pending[0];
         pending.delete(0);
         n_checked++;
         if (got.accepted !== e.accepted) report("accepted", got.accepted, e.accepted);
         if (got.dropped !== e.dropped) report("dropped", got.dropped, e.dropped);
         if (got.out_tag !== e.out_tag) report("out_tag", got.out_tag, e.out_tag);
         if (got.out_priority !== e.out_priority)
            report("out_priority", got.out_priority, e.out_priority);
         if (got.out_size !== e.out_size) report("out_size", got.out_size, e.out_size);
         if (got.queue_delay !== e.queue_delay)
            report("queue_delay", got.queue_delay, e.queue_delay);
         if (got.queued_bytes !== e.queued_bytes)
            report("queued_bytes", got.queued_bytes, e.queued_bytes);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wfq_req_if req_ch();
   wfq_rsp_if rsp_ch();

   weighted_fair_queue_scheduler_core #(
      .NUM_PRIO(NUM_PRIO),
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   wfq_scoreboard_type sched_model;
   int send_idle_pct;
   int recv_stall_pct;
   int cycles;
   logic [TIME_W-1:0] clock_ps;

   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.req_type = REQ_ENQ;
      req_ch.now = '0;
      req_ch.priority_req = '0;
      req_ch.pkt_size = '0;
      req_ch.pkt_tag = '0;
      rsp_ch.ready = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cycles = 0;
      sched_model = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // sample the result beat, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_type got;
         got.accepted = rsp_ch.accepted;
         got.dropped = rsp_ch.dropped;
         got.out_tag = rsp_ch.out_tag;
         got.out_priority = rsp_ch.out_priority;
         got.out_size = rsp_ch.out_size;
         got.queue_delay = rsp_ch.queue_delay;
         got.queued_bytes = rsp_ch.queued_bytes;
         sched_model.check_response(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task send_req(sched_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.req_type <= r.kind;
      req_ch.now <= r.stamp;
      req_ch.priority_req <= r.prio;
      req_ch.pkt_size <= r.size;
      req_ch.pkt_tag <= r.tag;
      do @(posedge clock); while (!req_ch.ready);
      sched_model.note_request(r);
   endtask

   task send_fields(logic kind, logic [TIME_W-1:0] stamp, int prio, int size, int tag);
      sched_req_type r;
      r.kind = kind;
      r.stamp = stamp;
      r.prio = PRIO_REQ_W'(prio);
      r.size = SIZE_W'(size);
      r.tag = TAG_W'(tag);
      send_req(r);
   endtask

   task wait_idle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sched_model.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sched_model.write_reg(idx, val);
   endtask

   task set_weights(int w0, int w1, int w2, int w3);
      write_csr(CSR_WEIGHT_0, CSR_DATA_W'(w0));
      write_csr(CSR_WEIGHT_1, CSR_DATA_W'(w1));
      write_csr(CSR_WEIGHT_2, CSR_DATA_W'(w2));
      write_csr(CSR_WEIGHT_3, CSR_DATA_W'(w3));
   endtask

   task run_random(int count, int deq_pct, int size_max, int prio_max);
      sched_req_type r;
      for (int k = 0; k < count; k++) begin
         r.kind = ($urandom_range(99) < deq_pct) ? REQ_DEQ : REQ_ENQ;
         // mostly advancing clock, sometimes a jump anywhere
         if ($urandom_range(99) < 4) clock_ps = TIME_W'({$urandom, $urandom});
         else clock_ps = clock_ps + TIME_W'($urandom_range(30000));
         r.stamp = clock_ps;
         r.prio = PRIO_REQ_W'($urandom_range(prio_max));
         r.size = SIZE_W'(($urandom_range(99) < 3) ? $urandom_range(16383)
                                                   : $urandom_range(size_max));
         r.tag = TAG_W'($urandom);
         send_req(r);
      end
   endtask

   task set_idle(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
         default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, empty dequeue, zero size, buffer overflow
      clock_ps = '0;
      send_fields(REQ_DEQ, 0, 0, 0, 0);
      send_fields(REQ_ENQ, 0, 0, 0, 0);
      send_fields(REQ_ENQ, 0, 1, 16383, 16'hFFFF);
      send_fields(REQ_ENQ, TIME_MAX, 2, 1, 16'h5A5A);
      send_fields(REQ_ENQ, 100, 3, 16383, 16'hA5A5);
      send_fields(REQ_ENQ, 200, 3, 16383, 1);
      send_fields(REQ_ENQ, 300, 0, 16383, 2);
      send_fields(REQ_ENQ, 400, 1, 16383, 3);
      send_fields(REQ_DEQ, TIME_MAX, 0, 0, 0);
      send_fields(REQ_DEQ, 0, 3, 16383, 16'hFFFF);
      repeat (7) send_fields(REQ_DEQ, 5000, 0, 0, 0);
      send_fields(REQ_DEQ, 6000, 0, 0, 0);
      wait_idle();

      set_idle(0);
      run_random(240, 45, 1500, 3);
      wait_idle();

      set_weights(1, 2, 4, 8);
      set_idle(1);
      run_random(240, 45, 1500, 3);
      wait_idle();

      // equal weights with a huge window: dequeues pick among tied heads
      set_weights(255, 255, 255, 255);
      write_csr(CSR_TIE_WINDOW, TIME_MAX);
      set_idle(2);
      run_random(240, 45, 1500, 3);
      wait_idle();

      // extreme scale: saturate finish times near the top of the clock
      set_weights(255, 1, 255, 1);
      write_csr(CSR_BYTE_TIME, CSR_DATA_W'(16'hFFFF));
      write_csr(CSR_BUF_LIMIT, CSR_DATA_W'(24'hFFFFFF));
      write_csr(CSR_TIE_WINDOW, '0);
      clock_ps = TIME_MAX - 48'd50000000;
      set_idle(3);
      run_random(240, 45, 16383, 3);
      wait_idle();

      // zero weights act as one; zero limit admits only empty packets
      set_weights(0, 0, 0, 0);
      write_csr(CSR_BUF_LIMIT, '0);
      write_csr(CSR_TIE_WINDOW, CSR_DATA_W'(1));
      clock_ps = '0;
      set_idle(0);
      run_random(120, 40, 2, 3);
      wait_idle();

      // fill one class past its depth
      write_csr(CSR_BYTE_TIME, CSR_DATA_W'(1));
      write_csr(CSR_BUF_LIMIT, CSR_DATA_W'(24'hFFFFFF));
      set_weights(3, 3, 3, 3);
      write_csr(CSR_TIE_WINDOW, 48'd1000000);
      set_idle(3);
      run_random(200, 8, 64, 0);
      run_random(100, 80, 64, 3);
      wait_idle();

      write_csr(CSR_BYTE_TIME, CSR_DATA_W'(BYTE_TIME_RST));
      write_csr(CSR_BUF_LIMIT, CSR_DATA_W'(24'd20000));
      set_idle(1);
      run_random(240, 40, 3000, 3);
      wait_idle();

      set_weights(200, 100, 50, 7);
      write_csr(CSR_BUF_LIMIT, CSR_DATA_W'(BUF_LIMIT_RST));
      set_idle(2);
      run_random(240, 50, 1500, 3);
      wait_idle();

      $display("covered %0d stored, %0d dropped, %0d served (%0d by tie pick), %0d empty",
               sched_model.n_stored, sched_model.n_drops, sched_model.n_served,
               sched_model.n_ties, sched_model.n_empty);
      $display("checked %0d result beats, %0d mismatches",
               sched_model.n_checked, sched_model.errors);
      if (sched_model.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/wfq_pkg.sv
design/wfq_if.sv
design/wfq_ram.sv
design/wfq_div.sv
design/weighted_fair_queue_scheduler_core.sv
tb/weighted_fair_queue_scheduler_core_tb.sv
